// ===== sv/owwm_pkg.sv =====
// Package for the online weight window median block.
// Holds sizes, codes, the sequencer state type and ring helpers; no dependencies.
package owwm_pkg;

    localparam int REP_DEPTH = 256;
    localparam int REP_AW    = $clog2(REP_DEPTH);
    localparam int REP_CW    = $clog2(REP_DEPTH + 1);
    localparam int WIN_MAX   = 64;
    localparam int WIN_AW    = $clog2(WIN_MAX);
    localparam int WIN_CW    = $clog2(WIN_MAX + 1);
    localparam int CNT_W     = WIN_CW + 1;

    localparam logic CFG_MIN_WEIGHT = 1'b0;
    localparam logic CFG_WIN_SIZE   = 1'b1;
    localparam logic ACT_OBSERVE    = 1'b0;
    localparam logic ACT_SAMPLE     = 1'b1;

    typedef enum logic [10:0] {
        ST_IDLE     = 11'b00000000001,
        ST_OBS_RD   = 11'b00000000010,
        ST_OBS_CHK  = 11'b00000000100,
        ST_SUM_RD   = 11'b00000001000,
        ST_SUM_ACC  = 11'b00000010000,
        ST_PLACE    = 11'b00000100000,
        ST_CAND_RD  = 11'b00001000000,
        ST_CAND_GET = 11'b00010000000,
        ST_CNT_RD   = 11'b00100000000,
        ST_CNT_CHK  = 11'b01000000000,
        ST_DONE     = 11'b10000000000
    } state_t;

    // base + off, wrapped into the ring
    function automatic logic [WIN_AW-1:0] ring_addr(input logic [WIN_AW-1:0] base,
                                                    input logic [WIN_CW-1:0] off);
        logic [WIN_CW:0] s;
        s = {{(WIN_CW + 1 - WIN_AW){1'b0}}, base} + {1'b0, off};
        if (s >= (WIN_CW + 1)'(WIN_MAX))
            s = s - (WIN_CW + 1)'(WIN_MAX);
        return s[WIN_AW-1:0];
    endfunction

    function automatic logic [WIN_CW-1:0] eff_window(input logic [6:0] ws);
        logic [WIN_CW-1:0] w;
        if (ws == 7'd0)
            w = WIN_CW'(1);
        else if ({25'd0, ws} > 32'(WIN_MAX))
            w = WIN_CW'(WIN_MAX);
        else
            w = WIN_CW'(ws);
        return w;
    endfunction

endpackage

// ===== sv/owwm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module owwm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

// ===== sv/online_weight_window_median_top.sv =====
// Top level of the online weight window median block.
// Depends on owwm_pkg and owwm_ram (id, weight and sample memories).
//
// Usage:
//  - Requests enter on in_valid/in_ready: action 0 observes (rep_id, rep_weight),
//    action 1 takes a sample and recomputes the trend. One result per request
//    leaves on out_valid/out_ready: live_stake, rep_count, set_overflow.
//  - Configuration writes go over cfg_valid/cfg_ready (always ready), index 0
//    minimum_weight, index 1 window_size. Write only while the block is idle.
//  - A sequencer drives a 64-bit adder and 64-bit comparators; every memory
//    read has an address state, then a state that uses the registered data.
//  - Observe: linear search of the id memory over the F ids in the set; zero
//    weight finishes without a search.
//  - Sample: the weights of the F ids are summed, the sum is placed in the ring,
//    then a rank select runs over the N = S+1 values (S samples plus the minimum).
//  - in_ready is high only when the sequencer is idle. A finished result sits
//    in the output register; the next request is taken while it waits, and
//    that request's result waits in the done state until out_ready.
//  - Reset (rst_n, asynchronous) empties the set and the sample window and
//    sets the trend to 0; memories are not cleared, only filled entries are read.
module online_weight_window_median_top
    import owwm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        action,
    input  logic [15:0] rep_id,
    input  logic [63:0] rep_weight,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] live_stake,
    output logic [8:0]  rep_count,
    output logic        set_overflow,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [63:0] cfg_data
);
    state_t state_reg, state_next;

    logic [63:0]       min_reg;
    logic [6:0]        win_reg;
    logic              act_reg;
    logic [15:0]       id_reg;
    logic [63:0]       wt_reg;
    logic              ovf_reg, ovf_next;
    logic [REP_CW-1:0] rep_fill_reg, rep_fill_next;
    logic [REP_CW-1:0] idx_reg, idx_next;
    logic [WIN_AW-1:0] oldest_reg, oldest_next;
    logic [WIN_CW-1:0] sfill_reg, sfill_next;
    logic [63:0]       trend_reg, trend_next;
    logic [63:0]       acc_reg, acc_next;       // sample sum, written into the ring
    logic [WIN_CW-1:0] cand_reg, cand_next;
    logic [WIN_CW-1:0] j_reg, j_next;
    logic [CNT_W-1:0]  less_reg, less_next;
    logic [CNT_W-1:0]  eq_reg, eq_next;
    logic [63:0]       cval_reg, cval_next;

    logic        out_valid_reg;
    logic [63:0] stake_reg;
    logic [8:0]  cnt_reg;
    logic        oflag_reg;
    logic        out_load;

    // memory ports
    logic              id_we;
    logic [15:0]       id_rdata;
    logic [63:0]       wt_rdata;
    logic              ring_we;
    logic [WIN_AW-1:0] ring_waddr, ring_raddr;
    logic [63:0]       ring_rdata;
    logic [WIN_CW-1:0] ring_off;

    // shared datapath pieces
    logic [64:0]       sum_wide;
    logic [63:0]       elem;
    logic [CNT_W-1:0]  less_upd, eq_upd;
    logic [CNT_W-1:0]  k_rank;
    logic [WIN_CW-1:0] win_eff, kept;
    logic [WIN_CW:0]   old_sum;

    owwm_ram #(.WIDTH(16), .DEPTH(REP_DEPTH)) u_id_ram (
        .clk   (clk),
        .we    (id_we),
        .waddr (rep_fill_reg[REP_AW-1:0]),
        .wdata (id_reg),
        .raddr (idx_reg[REP_AW-1:0]),
        .rdata (id_rdata)
    );

    owwm_ram #(.WIDTH(64), .DEPTH(REP_DEPTH)) u_wt_ram (
        .clk   (clk),
        .we    (id_we),
        .waddr (rep_fill_reg[REP_AW-1:0]),
        .wdata (wt_reg),
        .raddr (idx_reg[REP_AW-1:0]),
        .rdata (wt_rdata)
    );

    owwm_ram #(.WIDTH(64), .DEPTH(WIN_MAX)) u_ring_ram (
        .clk   (clk),
        .we    (ring_we),
        .waddr (ring_waddr),
        .wdata (acc_reg),
        .raddr (ring_raddr),
        .rdata (ring_rdata)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid    = out_valid_reg;
    assign live_stake   = stake_reg;
    assign rep_count    = cnt_reg;
    assign set_overflow = oflag_reg;

    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    // ring read follows the candidate during candidate fetch, else the count index
    assign ring_off   = (state_reg == ST_CAND_RD) ? cand_reg : j_reg;
    assign ring_raddr = ring_addr(oldest_reg, ring_off);

    assign sum_wide = {1'b0, acc_reg} + {1'b0, wt_rdata};
    assign elem     = (j_reg == sfill_reg) ? min_reg : ring_rdata;
    assign less_upd = less_reg + CNT_W'(elem < cval_reg);
    assign eq_upd   = eq_reg + CNT_W'(elem == cval_reg);
    assign k_rank   = CNT_W'((sfill_reg + WIN_CW'(1)) >> 1);

    // window trim for the new sample
    assign win_eff = eff_window(win_reg);
    assign kept    = (sfill_reg >= win_eff) ? (win_eff - WIN_CW'(1)) : sfill_reg;
    assign old_sum = {{(WIN_CW + 1 - WIN_AW){1'b0}}, oldest_reg}
                   + {1'b0, sfill_reg - kept};

    always_comb
    begin
        state_next    = state_reg;
        ovf_next      = ovf_reg;
        rep_fill_next = rep_fill_reg;
        idx_next      = idx_reg;
        oldest_next   = oldest_reg;
        sfill_next    = sfill_reg;
        trend_next    = trend_reg;
        acc_next      = acc_reg;
        cand_next     = cand_reg;
        j_next        = j_reg;
        less_next     = less_reg;
        eq_next       = eq_reg;
        cval_next     = cval_reg;
        id_we         = 1'b0;
        ring_we       = 1'b0;
        ring_waddr    = ring_addr(oldest_reg, sfill_reg);

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    ovf_next = 1'b0;
                    idx_next = '0;
                    acc_next = '0;
                    if (action == ACT_SAMPLE)
                        state_next = ST_SUM_RD;
                    else if (rep_weight == 64'd0)
                        state_next = ST_DONE;
                    else
                        state_next = ST_OBS_RD;
                end
            end
            ST_OBS_RD:
            begin
                if (idx_reg == rep_fill_reg)
                begin
                    if (rep_fill_reg == REP_CW'(REP_DEPTH))
                        ovf_next = 1'b1;
                    else
                    begin
                        id_we         = 1'b1;
                        rep_fill_next = rep_fill_reg + REP_CW'(1);
                    end
                    state_next = ST_DONE;
                end
                else
                    state_next = ST_OBS_CHK;
            end
            ST_OBS_CHK:
            begin
                if (id_rdata == id_reg)
                    state_next = ST_DONE;
                else
                begin
                    idx_next   = idx_reg + REP_CW'(1);
                    state_next = ST_OBS_RD;
                end
            end
            ST_SUM_RD:
            begin
                if (idx_reg == rep_fill_reg)
                    state_next = ST_PLACE;
                else
                    state_next = ST_SUM_ACC;
            end
            ST_SUM_ACC:
            begin
                acc_next   = sum_wide[64] ? {64{1'b1}} : sum_wide[63:0];
                idx_next   = idx_reg + REP_CW'(1);
                state_next = ST_SUM_RD;
            end
            ST_PLACE:
            begin
                // drop oldest samples, append the sum after the kept ones
                rep_fill_next = '0;
                if (old_sum >= (WIN_CW + 1)'(WIN_MAX))
                    oldest_next = WIN_AW'(old_sum - (WIN_CW + 1)'(WIN_MAX));
                else
                    oldest_next = old_sum[WIN_AW-1:0];
                ring_waddr = ring_addr(oldest_next, kept);
                ring_we    = 1'b1;
                sfill_next = kept + WIN_CW'(1);
                cand_next  = '0;
                state_next = ST_CAND_RD;
            end
            ST_CAND_RD:
                state_next = ST_CAND_GET;
            ST_CAND_GET:
            begin
                cval_next  = (cand_reg == sfill_reg) ? min_reg : ring_rdata;
                j_next     = '0;
                less_next  = '0;
                eq_next    = '0;
                state_next = ST_CNT_RD;
            end
            ST_CNT_RD:
                state_next = ST_CNT_CHK;
            ST_CNT_CHK:
            begin
                less_next = less_upd;
                eq_next   = eq_upd;
                if (j_reg == sfill_reg)
                begin
                    // candidate is the upper median when its rank span covers k
                    if (less_upd <= k_rank && k_rank < less_upd + eq_upd)
                    begin
                        trend_next = cval_reg;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        cand_next  = cand_reg + WIN_CW'(1);
                        state_next = ST_CAND_RD;
                    end
                end
                else
                begin
                    j_next     = j_reg + WIN_CW'(1);
                    state_next = ST_CNT_RD;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            min_reg       <= '0;
            win_reg       <= 7'(WIN_MAX);
            rep_fill_reg  <= '0;
            oldest_reg    <= '0;
            sfill_reg     <= '0;
            trend_reg     <= '0;
            out_valid_reg <= 1'b0;
            ovf_reg       <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rep_fill_reg <= rep_fill_next;
            oldest_reg   <= oldest_next;
            sfill_reg    <= sfill_next;
            trend_reg    <= trend_next;
            ovf_reg      <= ovf_next;
            if (cfg_valid && cfg_index == CFG_MIN_WEIGHT)
                min_reg <= cfg_data;
            if (cfg_valid && cfg_index == CFG_WIN_SIZE)
                win_reg <= cfg_data[6:0];
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        acc_reg  <= acc_next;
        cand_reg <= cand_next;
        j_reg    <= j_next;
        less_reg <= less_next;
        eq_reg   <= eq_next;
        cval_reg <= cval_next;
        if (in_valid && in_ready)
        begin
            act_reg <= action;
            id_reg  <= rep_id;
            wt_reg  <= rep_weight;
        end
        if (out_load)
        begin
            stake_reg <= (trend_reg > min_reg) ? trend_reg : min_reg;
            cnt_reg   <= 9'(rep_fill_reg);
            oflag_reg <= ovf_reg;
        end
    end

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");

    a_rep_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rep_fill_reg <= REP_CW'(REP_DEPTH))
        else $error("set fill beyond capacity");

    a_ring_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sfill_reg <= WIN_CW'(WIN_MAX))
        else $error("sample fill beyond window");

    a_sample_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && act_reg == ACT_SAMPLE) |=> (rep_count == 9'd0 && !set_overflow))
        else $error("sample result must report an empty set");
endmodule
